@@ rtl/hps_pkg.sv @@
// ----------------------------------------------------------------------------
// Percentile statistics package
// Shared widths, codes, interface structs and rank helpers.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int unsigned NumBinsDefault = 64;
  localparam int unsigned CountW         = 32;
  localparam int unsigned WidthW         = 20;
  localparam int unsigned TotalW         = 48;
  localparam int unsigned RankW          = 58;
  localparam int unsigned WaccW          = 64;
  localparam int unsigned StatW          = 32;
  localparam int unsigned DivDvdW        = 84;
  localparam int unsigned DivDsrW        = 50;
  localparam int unsigned OutDataW       = 264;
  localparam int unsigned OutEmptyBit    = 256;
  localparam int unsigned OutDropBit     = 257;

  localparam logic [WidthW-1:0] WidthReset = 20'd1000;

  typedef enum logic [1:0] {
    RANK_P50,
    RANK_P95,
    RANK_P99,
    RANK_P999
  } hps_rank_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RANK,
    ST_WALK,
    ST_MID,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_SPK_GO,
    ST_SPK_WAIT,
    ST_SPIKE,
    ST_DONE
  } hps_state_e;

  typedef struct packed {
    logic               start;
    logic [DivDvdW-1:0] dividend;
    logic [DivDsrW-1:0] divisor;
  } hps_div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivDvdW-1:0] quotient;
  } hps_div_rsp_t;

  // A running sum reaches ceil(total*p/d) exactly when sum*d >= total*p, so
  // the rank is kept scaled by its divisor and no division is needed.
  function automatic logic [RankW-1:0] rank_scaled(hps_rank_e k,
                                                   logic [TotalW-1:0] total);
    logic [RankW-1:0] t;
    t = RankW'(total);
    case (k)
      RANK_P50:  return t * RankW'(50);
      RANK_P95:  return t * RankW'(95);
      RANK_P99:  return t * RankW'(99);
      RANK_P999: return t * RankW'(999);
      default:   return '0;
    endcase
  endfunction

  // Running sum scaled by the divisor of the given rank.
  function automatic logic [RankW-1:0] cum_scaled(hps_rank_e k,
                                                  logic [TotalW-1:0] cum);
    logic [RankW-1:0] c;
    c = RankW'(cum);
    case (k)
      RANK_P999: return c * RankW'(1000);
      default:   return c * RankW'(100);
    endcase
  endfunction

endpackage

@@ rtl/hps_bin_mem.sv @@
// ----------------------------------------------------------------------------
// Bin count store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hps_bin_mem import hps_pkg::*; #(
  parameter int unsigned NUM_BINS = NumBinsDefault,
  localparam int unsigned AddrW   = $clog2(NUM_BINS)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [CountW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [CountW-1:0] rdata_o
);

  logic [CountW-1:0] mem_q [NUM_BINS];
  logic [CountW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/hps_divider.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module hps_divider import hps_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  hps_div_req_t req_i,
  output hps_div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DivDvdW + 1);

  logic               busy_q, done_q;
  logic [CntW-1:0]    cnt_q;
  logic [DivDvdW-1:0] dvd_q, quo_q;
  logic [DivDsrW-1:0] dsr_q, rem_q;
  logic [DivDsrW:0]   rem_sh;
  logic               ge;

  assign rem_sh = {rem_q, dvd_q[DivDvdW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivDvdW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DivDvdW-2:0], 1'b0};
      quo_q <= {quo_q[DivDvdW-2:0], ge};
      rem_q <= ge ? DivDsrW'(rem_sh - {1'b0, dsr_q}) : DivDsrW'(rem_sh);
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ rtl/histogram_percentile_stats.sv @@
// Bins load at one beat per cycle. After the last bin the result comes from
// a percentile walk over the bin store, two passes of the 84-bit serial
// divider (the mean and the spike start bin) and a spike walk from that bin
// when it lies within the loaded bins; an empty histogram skips all of these.
// Throughput: one histogram at a time; the next one loads once the result sits
// in the output register. Reset clears control state and sets 1000 ns width.
// ----------------------------------------------------------------------------
// Histogram percentile statistics
// Loads histogram bins into a store, then walks it for percentiles and the
// count of spike samples; the mean comes from a weighted sum kept while loading.
// ----------------------------------------------------------------------------
module histogram_percentile_stats import hps_pkg::*; #(
  parameter int unsigned NUM_BINS = NumBinsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WidthW-1:0]   cfg_wdata_i,   // bucket_width_ns
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [CountW-1:0]   s_tdata_i,     // bin_count
  input  logic                s_tlast_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  // m_tdata_o from bit 0: p50_ns, p95_ns, p99_ns, p999_ns, mean_ns,
  // spike_count, sample_total, histogram_empty, bins_dropped, zero padding
  output logic [OutDataW-1:0] m_tdata_o
);

  localparam int unsigned AddrW = $clog2(NUM_BINS);
  localparam int unsigned CntW  = $clog2(NUM_BINS + 1);
  localparam int unsigned MidW  = AddrW + WidthW + 1;
  localparam int unsigned PadW  = OutDataW - OutDropBit - 1;

  hps_state_e state_q, state_d;

  logic [WidthW-1:0]   width_q, w_eff;
  logic [CntW-1:0]     bins_loaded_q;
  logic [TotalW-1:0]   total_q, total_add;
  logic [WaccW-1:0]    wacc_q;
  logic                ovf_q;
  logic [RankW-1:0]    thr_q [4];
  logic [TotalW-1:0]   cum_q, cum_sum;
  logic [RankW-1:0]    cum_pct, cum_pmil;
  logic [3:0]          found_q, hit;
  logic [AddrW-1:0]    idx_q [4];
  logic [StatW-1:0]    mid_q [4];
  logic [CntW-1:0]     walk_cnt_q;
  logic                pend_q;
  logic [AddrW-1:0]    pend_idx_q;
  logic [DivDvdW-1:0]  prod_q;
  logic [StatW-1:0]    mean_q;
  logic [TotalW-1:0]   spike_q;
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  logic                     in_fire, store_en, rd_en, out_load, spike_go, empty;
  logic [CountW-1:0]        rd_data;
  logic [CountW+CntW:0]     wprod;
  logic [CountW+WidthW-1:0] mul_lo, mul_hi;
  hps_div_req_t             div_req;
  hps_div_rsp_t             div_rsp;

  // A zero width is treated as one nanosecond.
  assign w_eff = (width_q == '0) ? WidthW'(1) : width_q;

  assign in_fire   = s_tvalid_i && s_tready_o;
  assign store_en  = in_fire && (bins_loaded_q < CntW'(NUM_BINS));
  assign total_add = total_q + (store_en ? TotalW'(s_tdata_i) : '0);
  assign wprod     = s_tdata_i * {bins_loaded_q, 1'b1};
  assign mul_lo    = wacc_q[31:0] * w_eff;
  assign mul_hi    = wacc_q[63:32] * w_eff;
  assign cum_sum   = cum_q + TotalW'(rd_data);
  assign cum_pct   = cum_scaled(RANK_P50, cum_sum);
  assign cum_pmil  = cum_scaled(RANK_P999, cum_sum);
  assign spike_go  = div_rsp.quotient < DivDvdW'(bins_loaded_q);
  assign empty     = total_q == '0;

  // A percentile is found at the first bin whose scaled running sum reaches
  // its scaled rank.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hit[k] = !found_q[k] &&
               (((k == int'(RANK_P999)) ? cum_pmil : cum_pct) >= thr_q[k]);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_fire && s_tlast_i) begin
          state_d = (total_add == '0) ? ST_DONE : ST_RANK;
        end
      end
      ST_RANK:      state_d = ST_WALK;
      ST_WALK: begin
        if (!rd_en && !pend_q) begin
          state_d = ST_MID;
        end
      end
      ST_MID:       state_d = ST_MUL_LO;
      ST_MUL_LO:    state_d = ST_MUL_HI;
      ST_MUL_HI:    state_d = ST_MEAN_GO;
      ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_SPK_GO;
        end
      end
      ST_SPK_GO:    state_d = ST_SPK_WAIT;
      ST_SPK_WAIT: begin
        if (div_rsp.done) begin
          state_d = spike_go ? ST_SPIKE : ST_DONE;
        end
      end
      ST_SPIKE: begin
        if (!rd_en && !pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Outputs of the sequencer. The store is written only while loading and
  // read only while walking, so reads and writes never overlap.
  always_comb begin
    s_tready_o       = 1'b0;
    rd_en            = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = DivDsrW'({total_q, 1'b0});
    case (state_q)
      ST_LOAD:    s_tready_o = 1'b1;
      ST_WALK,
      ST_SPIKE:   rd_en = walk_cnt_q < bins_loaded_q;
      ST_MEAN_GO: div_req.start = 1'b1;
      ST_SPK_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DivDvdW'({mid_q[0], 3'b000}) + DivDvdW'({mid_q[0], 1'b0});
        div_req.divisor  = DivDsrW'(w_eff);
      end
      ST_DONE:    out_load = !m_valid_q || m_tready_i;
      default:    ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_LOAD;
      width_q       <= WidthReset;
      bins_loaded_q <= '0;
      total_q       <= '0;
      wacc_q        <= '0;
      ovf_q         <= 1'b0;
      walk_cnt_q    <= '0;
      pend_q        <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_en;
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (store_en) begin
        bins_loaded_q <= bins_loaded_q + 1'b1;
        total_q       <= total_add;
        wacc_q        <= wacc_q + WaccW'(wprod);
      end else if (in_fire) begin
        ovf_q <= 1'b1;
      end
      if (in_fire && s_tlast_i) begin
        walk_cnt_q <= '0;
      end
      if (rd_en) begin
        walk_cnt_q <= walk_cnt_q + 1'b1;
      end
      if (state_q == ST_SPK_WAIT && div_rsp.done) begin
        walk_cnt_q <= div_rsp.quotient[CntW-1:0];
      end
      if (out_load) begin
        m_valid_q     <= 1'b1;
        bins_loaded_q <= '0;
        total_q       <= '0;
        wacc_q        <= '0;
        ovf_q         <= 1'b0;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, all set before use within one histogram.
  always_ff @(posedge clk_i) begin
    if (in_fire && s_tlast_i) begin
      cum_q   <= '0;
      found_q <= '0;
      for (int k = 0; k < 4; k++) begin
        idx_q[k] <= '0;
      end
    end
    if (state_q == ST_RANK) begin
      thr_q[RANK_P50]  <= rank_scaled(RANK_P50, total_q);
      thr_q[RANK_P95]  <= rank_scaled(RANK_P95, total_q);
      thr_q[RANK_P99]  <= rank_scaled(RANK_P99, total_q);
      thr_q[RANK_P999] <= rank_scaled(RANK_P999, total_q);
    end
    if (rd_en) begin
      pend_idx_q <= walk_cnt_q[AddrW-1:0];
    end
    if (pend_q && state_q == ST_WALK) begin
      cum_q   <= cum_sum;
      found_q <= found_q | hit;
      for (int k = 0; k < 4; k++) begin
        if (hit[k]) begin
          idx_q[k] <= pend_idx_q;
        end
      end
    end
    if (state_q == ST_MID) begin
      for (int k = 0; k < 4; k++) begin
        mid_q[k] <= StatW'(MidW'(idx_q[k]) * MidW'(w_eff) + MidW'(w_eff >> 1));
      end
    end
    if (state_q == ST_MUL_LO) begin
      prod_q <= DivDvdW'(mul_lo);
    end
    if (state_q == ST_MUL_HI) begin
      prod_q <= prod_q + DivDvdW'({mul_hi, 32'h0});
    end
    if (state_q == ST_MEAN_WAIT && div_rsp.done) begin
      mean_q <= div_rsp.quotient[StatW-1:0];
    end
    if (state_q == ST_SPK_WAIT && div_rsp.done) begin
      spike_q <= '0;
    end
    if (pend_q && state_q == ST_SPIKE) begin
      spike_q <= spike_q + TotalW'(rd_data);
    end
    if (out_load) begin
      if (empty) begin
        m_data_q <= {PadW'(0), ovf_q, 1'b1, {OutEmptyBit{1'b0}}};
      end else begin
        m_data_q <= {PadW'(0), ovf_q, 1'b0, total_q, spike_q, mean_q,
                     mid_q[3], mid_q[2], mid_q[1], mid_q[0]};
      end
    end
  end

  hps_bin_mem #(
    .NUM_BINS (NUM_BINS)
  ) u_bin_mem (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (bins_loaded_q[AddrW-1:0]),
    .wdata_i (s_tdata_i),
    .re_i    (rd_en),
    .raddr_i (walk_cnt_q[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  hps_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  // The fill count never passes the store depth.
  a_bins_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bins_loaded_q <= CntW'(NUM_BINS))
    else $error("bin count beyond store depth");

  // An empty histogram shows only zero statistics.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[OutEmptyBit]) |-> (m_data_q[OutEmptyBit-1:0] == '0))
    else $error("empty histogram with non-zero statistics");

  // Handing over a result clears the histogram and reopens the input.
  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (bins_loaded_q == '0) && (total_q == '0) && s_tready_o)
    else $error("histogram not cleared after result");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Histogram percentile statistics testbench
// Streams latency histograms into the block, one bin per beat, and checks
// each statistics beat against an in-bench model of the percentile walk,
// the mean division and the spike count, across several bin widths.
// ----------------------------------------------------------------------------
module tb;
  import hps_pkg::*;

  localparam int unsigned NBins     = NumBinsDefault;
  localparam int unsigned CycleCap  = 3_000_000;
  localparam int unsigned DrainWait = 2 * NBins + 600;

  // One expected statistics beat, field by field.
  typedef struct {
    logic [StatW-1:0]  p50;
    logic [StatW-1:0]  p95;
    logic [StatW-1:0]  p99;
    logic [StatW-1:0]  p999;
    logic [StatW-1:0]  mean;
    logic [TotalW-1:0] spikes;
    logic [TotalW-1:0] total;
    logic              empty;
    logic              dropped;
  } hist_stats_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [WidthW-1:0]   cfg_wdata_i = '0;
  logic                s_tvalid_i = 1'b0;
  logic                s_tready_o;
  logic [CountW-1:0]   s_tdata_i = '0;
  logic                s_tlast_i = 1'b0;
  logic                m_tvalid_o;
  logic                m_tready_i = 1'b0;
  logic [OutDataW-1:0] m_tdata_o;

  // Shadow of the block: bin width register and the histogram being loaded.
  logic [WidthW-1:0]   width_reg = WidthReset;
  logic [CountW-1:0]   bin_copy [NBins];
  int unsigned         bins_held = 0;
  logic [63:0]         count_sum = '0;
  logic [63:0]         wsum_acc = '0;
  logic                overflowed = 1'b0;

  hist_stats_t         stats_due[$];
  int unsigned         fail_count = 0;
  int unsigned         cycle_count = 0;
  bit                  no_gaps = 1'b0;

  always #1 clk_i = ~clk_i;

  histogram_percentile_stats dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),     // bin_count
    .s_tlast_i   (s_tlast_i),     // last_bin
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    // from bit 0: p50, p95, p99, p999, mean, spikes, total, empty, dropped
    .m_tdata_o   (m_tdata_o)
  );

  // Folds one accepted bin into the shadow histogram. On the last bin it
  // works out the statistics beat and queues it, then clears the histogram.
  function automatic void account_bin(logic [CountW-1:0] count, logic last);
    hist_stats_t    st;
    logic [63:0]    w, tot, run;
    logic [63:0]    rank [4];
    logic [StatW-1:0] mid [4];
    bit             hit [4];
    logic [127:0]   num;
    logic [63:0]    spike_start;
    if (bins_held < NBins) begin
      bin_copy[bins_held] = count;
      count_sum += count;
      wsum_acc += 64'(count) * (2 * 64'(bins_held) + 1);
      bins_held++;
    end else begin
      overflowed = 1'b1;
    end
    if (!last) return;

    tot = count_sum & 64'hFFFF_FFFF_FFFF;
    st = '{default: '0};
    st.total = tot[TotalW-1:0];
    st.dropped = overflowed;
    if (tot == 0) begin
      st.empty = 1'b1;
    end else begin
      w = (width_reg == 0) ? 64'd1 : 64'(width_reg);
      rank[0] = (tot * 50 + 99) / 100;
      rank[1] = (tot * 95 + 99) / 100;
      rank[2] = (tot * 99 + 99) / 100;
      rank[3] = (tot * 999 + 999) / 1000;
      foreach (mid[k]) begin
        mid[k] = '0;
        hit[k] = 1'b0;
      end
      run = '0;
      // First bin whose running sum reaches each rank; bin 0 is a real
      // answer, hence the separate hit flags.
      for (int unsigned i = 0; i < bins_held; i++) begin
        run += bin_copy[i];
        for (int k = 0; k < 4; k++) begin
          if (!hit[k] && run >= rank[k]) begin
            hit[k] = 1'b1;
            mid[k] = StatW'(64'(i) * w + w / 2);
          end
        end
      end
      // A rank never reached would leave bin 0; the rank is at most the
      // total, so that cannot happen, but bin 0 midpoint covers it anyway.
      foreach (mid[k]) if (!hit[k]) mid[k] = StatW'(w / 2);
      st.p50 = mid[0];
      st.p95 = mid[1];
      st.p99 = mid[2];
      st.p999 = mid[3];
      num = 128'(wsum_acc) * 128'(w);
      st.mean = StatW'(num / (128'(tot) * 2));
      spike_start = (64'(st.p50) * 10) / w;
      if (spike_start < 64'(bins_held)) begin
        for (int unsigned i = 32'(spike_start); i < bins_held; i++)
          st.spikes += bin_copy[i];
      end
    end
    stats_due.insert(stats_due.size(), st);
    bins_held = 0;
    count_sum = '0;
    wsum_acc = '0;
    overflowed = 1'b0;
  endfunction

  // Sends one bin beat after a random gap; called and returns at a falling edge.
  task automatic send_bin(input logic [CountW-1:0] count, input logic last);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i = 1'b1;
    s_tdata_i = count;
    s_tlast_i = last;
    do @(posedge clk_i); while (!s_tready_o);
    account_bin(count, last);
    @(negedge clk_i);
  endtask

  // Waits until every queued statistics beat has come out.
  task automatic drain;
    s_tvalid_i = 1'b0;
    while (stats_due.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  // Bin width write; only ever issued with the block idle.
  task automatic set_width(input logic [WidthW-1:0] w);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = w;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    width_reg = w;
  endtask

  function automatic logic [CountW-1:0] pick_count;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return $urandom_range(1, 3);
      2:       return $urandom_range(0, 1000);
      3:       return $urandom;
      default: return $urandom_range(0, 100_000);
    endcase
  endfunction

  // Sends a whole histogram of n bins with random counts.
  task automatic send_histogram(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_bin(pick_count(), i == n - 1);
  endtask

  // Extremes of the bin count, bin zero holding the median, an empty
  // histogram, a single bin and a spike start beyond the loaded bins.
  task automatic test_directed;
    send_bin(32'd5, 1'b1);
    send_bin(32'd0, 1'b0);
    send_bin(32'd0, 1'b0);
    send_bin(32'd0, 1'b1);
    send_bin(32'hFFFF_FFFF, 1'b0);
    send_bin(32'hFFFF_FFFF, 1'b0);
    send_bin(32'hFFFF_FFFF, 1'b1);
    send_bin(32'd100, 1'b0);
    send_bin(32'd0, 1'b0);
    send_bin(32'd0, 1'b0);
    send_bin(32'd1, 1'b1);
    send_bin(32'd0, 1'b0);
    send_bin(32'd0, 1'b0);
    send_bin(32'd0, 1'b0);
    send_bin(32'd7, 1'b1);
    send_bin(32'd1, 1'b0);
    send_bin(32'd1, 1'b1);
    send_bin(32'd0, 1'b1);
  endtask

  // A full store, then histograms past capacity: the bins beyond the store are
  // dropped but the last still closes the histogram; one is all zeros, so empty.
  task automatic test_store_full;
    send_histogram(NBins);
    send_histogram(NBins + 6);
    for (int unsigned i = 0; i < NBins + 2; i++) send_bin('0, i == NBins + 1);
  endtask

  // A directed and a full random histogram under each extreme and odd width.
  task automatic test_widths;
    logic [WidthW-1:0] widths [4];
    widths = '{20'd1, 20'hFFFFF, 20'd0, 20'd7};
    foreach (widths[j]) begin
      set_width(widths[j]);
      send_bin(32'd1, 1'b0);
      send_bin(32'hFFFF_FFFF, 1'b0);
      send_bin(32'd3, 1'b1);
      send_histogram(NBins);
    end
  endtask

  // The sender holds off until the block has answered everything so far.
  task automatic test_hold_off;
    send_histogram(5);
    drain();
    send_histogram(3);
  endtask

  // Mostly short histograms with random content and random widths, some
  // long or overflowing ones, stretches of back-to-back beats in between.
  task automatic test_random;
    int unsigned sent, n;
    sent = 0;
    while (sent < 700) begin
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 3))
          0:       set_width(20'd1);
          1:       set_width(20'hFFFFF);
          default: set_width($urandom_range(1, 5000));
        endcase
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 15))
        0:       n = $urandom_range(NBins - 2, NBins + 4);
        1:       n = $urandom_range(16, NBins);
        default: n = $urandom_range(1, 10);
      endcase
      send_histogram(n);
      sent += n;
    end
    no_gaps = 1'b0;
  endtask

  // Receiver: a random stall before each beat, none during back-to-back stretches.
  initial begin
    hist_stats_t st;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = no_gaps ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      if (stats_due.size() == 0) begin
        $display("%0t: statistics beat with none expected: %h", $time, m_tdata_o);
        fail_count++;
      end else begin
        st = stats_due.pop_front();
        if (m_tdata_o[31:0] !== st.p50) begin
          $display("%0t: p50 expected %0d actual %0d", $time, st.p50, m_tdata_o[31:0]);
          fail_count++;
        end
        if (m_tdata_o[63:32] !== st.p95) begin
          $display("%0t: p95 expected %0d actual %0d", $time, st.p95, m_tdata_o[63:32]);
          fail_count++;
        end
        if (m_tdata_o[95:64] !== st.p99) begin
          $display("%0t: p99 expected %0d actual %0d", $time, st.p99, m_tdata_o[95:64]);
          fail_count++;
        end
        if (m_tdata_o[127:96] !== st.p999) begin
          $display("%0t: p99.9 expected %0d actual %0d", $time, st.p999,
                   m_tdata_o[127:96]);
          fail_count++;
        end
        if (m_tdata_o[159:128] !== st.mean) begin
          $display("%0t: mean expected %0d actual %0d", $time, st.mean,
                   m_tdata_o[159:128]);
          fail_count++;
        end
        if (m_tdata_o[207:160] !== st.spikes) begin
          $display("%0t: spikes expected %0d actual %0d", $time, st.spikes,
                   m_tdata_o[207:160]);
          fail_count++;
        end
        if (m_tdata_o[255:208] !== st.total) begin
          $display("%0t: total expected %0d actual %0d", $time, st.total,
                   m_tdata_o[255:208]);
          fail_count++;
        end
        if (m_tdata_o[OutEmptyBit] !== st.empty) begin
          $display("%0t: empty expected %0b actual %0b", $time, st.empty,
                   m_tdata_o[OutEmptyBit]);
          fail_count++;
        end
        if (m_tdata_o[OutDropBit] !== st.dropped) begin
          $display("%0t: dropped expected %0b actual %0b", $time, st.dropped,
                   m_tdata_o[OutDropBit]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleCap) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_store_full();
    test_widths();
    set_width(WidthReset);
    test_hold_off();
    test_random();
    drain();
    repeat (DrainWait) @(negedge clk_i);
    if (fail_count == 0 && stats_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hps_pkg.sv
rtl/hps_bin_mem.sv
rtl/hps_divider.sv
rtl/histogram_percentile_stats.sv
tb/tb.sv
